FILE: design/afk_pkg.sv
// ----------------------------------------------------------------------------
// afk_pkg
// shared types, constants and the sine/cosine helper functions
// ----------------------------------------------------------------------------
package afk_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int PHASE_BITS = 24;
  localparam int TRIG_W     = 16;
  localparam int POS_W      = 18;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 184;
  localparam int QDEPTH     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SHOULDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOREARM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRIST    = 3'd4;

  localparam logic [PHASE_BITS-1:0] QUARTER = 24'h400000;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  // front-to-back queue entry: three phases plus the sum of the last two
  typedef struct packed {
    phase_t p1;
    phase_t p2;
    phase_t p3;
    phase_t p23;
  } phases_t;

  typedef struct packed {
    logic [CFG_W-1:0] sh;
    logic [CFG_W-1:0] bh;
    logic [CFG_W-1:0] ua;
    logic [CFG_W-1:0] fa;
    logic [CFG_W-1:0] wo;
  } cfg_t;

  function automatic phase_t to_phase(input logic [ANGLE_BITS-1:0] a);
    to_phase = phase_t'({a, {(PHASE_BITS-ANGLE_BITS){1'b0}}});
  endfunction

  // polynomial sine split in steps, quadrant handled by caller
  // mirrored quarter-turn fraction in Q15
  function automatic logic [15:0] sin_x15(input phase_t ph);
    logic [22:0] x;
    x = ph[22] ? (23'h400000 - {1'b0, ph[21:0]}) : {1'b0, ph[21:0]};
    sin_x15 = x[22:7];
  endfunction

  // x squared in Q15
  function automatic logic [16:0] sin_sq(input logic [15:0] x15);
    logic [31:0] p;
    p = 32'(x15) * 32'(x15);
    sin_sq = p[31:15];
  endfunction

  // inner part A - x^2 (B - x^2 C)
  function automatic logic [16:0] sin_poly(input logic [16:0] x2);
    logic [33:0] p;
    logic [16:0] t;
    p = 34'(x2) * 34'd2320;
    t = 17'd21024 - p[31:15];
    p = 34'(t) * 34'(x2);
    sin_poly = 17'd51472 - p[31:15];
  endfunction

  // final product and rounding to Q14
  function automatic logic [15:0] sin_fin(input logic [16:0] t, input logic [15:0] x15);
    logic [32:0] p;
    logic [16:0] y;
    p = 33'(t) * 33'(x15);
    y = p[31:15] + 17'd1;
    sin_fin = y[16:1];
  endfunction

endpackage

FILE: design/afk_front.sv
// ----------------------------------------------------------------------------
// afk_front
// input stage: angles to phases, joint sum, short queue toward the back end
// ----------------------------------------------------------------------------
module afk_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [afk_pkg::IN_W-1:0] in_data,
  output logic                   q_valid,
  input  logic                   q_ready,
  output afk_pkg::phases_t       q_data
);
  import afk_pkg::*;

  phases_t             mem_r [QDEPTH];
  logic                wp_r, rp_r;
  logic [1:0]          cnt_r;
  phases_t             ent;
  logic                push, pop;

  always_comb begin
    ent.p1  = to_phase(in_data[15:0]);
    ent.p2  = to_phase(in_data[31:16]);
    ent.p3  = to_phase(in_data[47:32]);
    ent.p23 = ent.p2 + ent.p3;
  end

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QDEPTH))
    else $error("queue count overflow");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QDEPTH)) |-> !push) else $error("push into full queue");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !push) |=> !q_valid) else $error("phantom entry");
endmodule

FILE: design/afk_back.sv
// ----------------------------------------------------------------------------
// afk_back
// pipelined trig, kinematics products, rounding and saturation
// ----------------------------------------------------------------------------
module afk_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  afk_pkg::phases_t         q_data,
  input  afk_pkg::cfg_t            cfg,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [afk_pkg::OUT_W-1:0] out_tdata
);
  import afk_pkg::*;

  localparam int NST = 8;

  logic [NST-1:0] v_r;
  logic           adv;

  // stage 1: sine argument and its square
  phases_t        ph_r;
  logic [15:0]    x15_r [8];
  logic [16:0]    x2_r [8];
  logic [1:0]     qa_r [8];
  // stage 2: inner polynomial
  logic [16:0]    u_r [8];
  logic [15:0]    x15b_r [8];
  logic [1:0]     qb_r [8];
  // stage 3: sine magnitudes
  logic [15:0]    m_r [8];
  logic [1:0]     qd_r [8];
  // stage 4: signed trig
  trig_t          s1_r, c1_r, s2_r, c2_r, s3_r, c3_r, s23_r, c23_r;
  // stage 5: a, b (Q14) and rotation products
  logic signed [33:0] a_r, b_r;
  trig_t          r01_r, r02_r, r11_r, r12_r;
  trig_t          s1_3, c1_3, s2_3, c2_3, s23_3, c23_3;
  // stage 6: r, z
  logic signed [50:0] rr_r, z_r;
  trig_t          s1_4, c1_4, s23_4, c23_4, r01_4, r02_4, r11_4, r12_4;
  // stage 7: x, y
  logic signed [67:0] x_r, y_r;
  logic signed [50:0] z_5;
  trig_t          s1_5, c1_5, s23_5, c23_5, r01_5, r02_5, r11_5, r12_5;
  // stage 8: output register
  logic [OUT_W-1:0] od_r;

  phase_t         phs [8];
  trig_t          sg [8];

  function automatic trig_t rnd14(input logic signed [31:0] p);
    logic signed [31:0] t;
    t = p + 32'sd8192;
    rnd14 = trig_t'(t >>> 14);
  endfunction

  function automatic logic [POS_W-1:0] sat(input logic signed [67:0] v, input int k);
    logic signed [67:0] t;
    t = (v + (68'sd1 <<< (k - 1))) >>> k;
    if (t > 68'sd131071) sat = 18'h1FFFF;
    else if (t < -68'sd131072) sat = 18'h20000;
    else sat = t[POS_W-1:0];
  endfunction

  assign adv     = !v_r[NST-1] || out_tready;
  assign q_ready = adv;
  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = od_r;

  always_comb begin
    phs[0] = q_data.p1;  phs[1] = q_data.p1 + QUARTER;
    phs[2] = q_data.p2;  phs[3] = q_data.p2 + QUARTER;
    phs[4] = q_data.p3;  phs[5] = q_data.p3 + QUARTER;
    phs[6] = q_data.p23; phs[7] = q_data.p23 + QUARTER;
    for (int i = 0; i < 8; i++) begin
      sg[i] = qd_r[i][1] ? -trig_t'(m_r[i]) : trig_t'(m_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r <= q_data;
      for (int i = 0; i < 8; i++) begin
        x15_r[i]  <= sin_x15(phs[i]);
        x2_r[i]   <= sin_sq(sin_x15(phs[i]));
        qa_r[i]   <= phs[i][23:22];
        u_r[i]    <= sin_poly(x2_r[i]);
        x15b_r[i] <= x15_r[i];
        qb_r[i]   <= qa_r[i];
        m_r[i]    <= sin_fin(u_r[i], x15b_r[i]);
        qd_r[i]   <= qb_r[i];
      end
      s1_r <= sg[0]; c1_r <= sg[1]; s2_r <= sg[2]; c2_r <= sg[3];
      s3_r <= sg[4]; c3_r <= sg[5]; s23_r <= sg[6]; c23_r <= sg[7];
      // stage 5
      a_r <= 34'($signed({1'b0, cfg.wo}) * c3_r) - 34'($signed({1'b0, cfg.fa}) * s3_r);
      b_r <= 34'($signed({1'b0, cfg.fa}) * c3_r) + 34'($signed({1'b0, cfg.wo}) * s3_r)
             + 34'($signed({1'b0, cfg.ua, 14'd0}));
      r01_r <= rnd14(32'(c23_r * c1_r));
      r02_r <= rnd14(32'(s23_r * c1_r));
      r11_r <= rnd14(32'(c23_r * s1_r));
      r12_r <= rnd14(32'(s23_r * s1_r));
      s1_3 <= s1_r; c1_3 <= c1_r; s2_3 <= s2_r; c2_3 <= c2_r;
      s23_3 <= s23_r; c23_3 <= c23_r;
      // stage 6
      rr_r <= 51'(s2_3 * a_r) + 51'(c2_3 * b_r);
      z_r  <= 51'(c2_3 * a_r) - 51'(s2_3 * b_r) + 51'($signed({1'b0, cfg.bh, 28'd0}));
      s1_4 <= s1_3; c1_4 <= c1_3; s23_4 <= s23_3; c23_4 <= c23_3;
      r01_4 <= r01_r; r02_4 <= r02_r; r11_4 <= r11_r; r12_4 <= r12_r;
      // stage 7
      x_r <= 68'(c1_4 * rr_r) - 68'($signed({1'b0, cfg.sh}) * s1_4) * 68'sd268435456;
      y_r <= 68'(s1_4 * rr_r) + 68'($signed({1'b0, cfg.sh}) * c1_4) * 68'sd268435456;
      z_5 <= z_r;
      s1_5 <= s1_4; c1_5 <= c1_4; s23_5 <= s23_4; c23_5 <= c23_4;
      r01_5 <= r01_4; r02_5 <= r02_4; r11_5 <= r11_4; r12_5 <= r12_4;
      // stage 8
      od_r <= {2'b00, sat(68'(z_5), 28), sat(y_r, 42), sat(x_r, 42), c23_5, -s23_5,
               r12_5, r11_5, -c1_5, r02_5, r01_5, s1_5};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid) |-> q_ready) else $error("pipe stalled with empty output");
  a_ph: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && q_valid) |=> (ph_r.p23 == ph_r.p2 + ph_r.p3)) else $error("joint sum wrong");
endmodule

FILE: design/afk_cfg.sv
// ----------------------------------------------------------------------------
// afk_cfg
// link offset register file
// ----------------------------------------------------------------------------
module afk_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [afk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afk_pkg::CFG_W-1:0]   cfg_data,
  output afk_pkg::cfg_t               cfg
);
  import afk_pkg::*;

  cfg_t cfg_r;
  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sh <= 16'd7143;
      cfg_r.bh <= 16'd5846;
      cfg_r.ua <= 16'd27853;
      cfg_r.fa <= 16'd31850;
      cfg_r.wo <= 16'd13959;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SHOULDER: cfg_r.sh <= cfg_data;
        REG_BASE_H:   cfg_r.bh <= cfg_data;
        REG_UPPER:    cfg_r.ua <= cfg_data;
        REG_FOREARM:  cfg_r.fa <= cfg_data;
        REG_WRIST:    cfg_r.wo <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

FILE: design/arm_forward_kinematics_3dof.sv
// ----------------------------------------------------------------------------
// arm_forward_kinematics_3dof
// hand pose of a three-joint arm from binary joint angles
// ----------------------------------------------------------------------------
// one item in, one pose out, one item per cycle sustained while the output is
// taken. the front end turns the three angles into 24-bit phases and the summed
// elbow phase and drops the item into a two-entry queue; the back end is an
// eight-stage pipeline (three stages of sine polynomial, signed trig, link
// terms, r and z, x and y, rounding with saturation) that advances whenever its
// output register is free or taken. an accepted item waits in the queue and
// then passes through the back-end stages in order. a held output stalls the
// whole back end; the queue then fills and in_tready drops while it holds two
// items. link offsets must be written through the cfg port only while the
// block is idle, which the block does not enforce; unknown indexes are ignored.
module arm_forward_kinematics_3dof (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // base_angle, shoulder_angle, elbow_angle (16 bits each, lowest first)
  input  logic [47:0]   in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_21, rot_22 (16 each),
  // pos_x, pos_y, pos_z (18 each), lowest first
  output logic [183:0]  out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import afk_pkg::*;

  logic    q_valid, q_ready;
  phases_t q_data;
  cfg_t    cfg;

  afk_cfg u_cfg (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
  );

  // front end: phase conversion and queue
  afk_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata),
    .q_valid, .q_ready, .q_data
  );

  // back end: trig and kinematics pipeline
  afk_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .cfg,
    .out_tvalid, .out_tready, .out_tdata
  );
endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks arm_forward_kinematics_3dof against a behavioral pose predictor
// ----------------------------------------------------------------------------
// joint angle items go in through a stream with random gaps, poses come out
// with random back pressure. every pose is compared field by field with the
// oldest predicted pose. link offsets are rewritten between phases while the
// block is drained, including all-zero and all-ones settings.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import afk_pkg::*;

  typedef struct {
    logic signed [15:0] rot [8];
    logic signed [17:0] pos [3];
  } pose_t;

  typedef struct {
    logic [15:0] q1, q2, q3;
    bit          fixed;    // expected rot_00 and rot_10 typed in below
    logic [15:0] r00, r10; // sin q1 and -cos q1
  } angle_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [47:0]   in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [183:0]  out_tdata;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = '0;
  logic [15:0]   cfg_data = '0;

  // predictor copy of the link offsets
  logic [15:0] link_reg [5];
  pose_t       pose_q [$];
  int          mismatch_count = 0;
  bit          hold_off_idle = 0;

  arm_forward_kinematics_3dof dut (.*);

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic longint sine14(logic [23:0] ph);
    longint unsigned x, x15, x2, t, y;
    x = ph[22] ? (64'h400000 - ph[21:0]) : ph[21:0];
    x15 = x >> 7;
    x2 = (x15 * x15) >> 15;
    t = 21024 - ((2320 * x2) >> 15);
    t = 51472 - ((t * x2) >> 15);
    t = (t * x15) >> 15;
    y = (t + 1) >> 1;
    return ph[23] ? -longint'(y) : longint'(y);
  endfunction

  function automatic longint cosine14(logic [23:0] ph);
    return sine14(ph + 24'h400000);
  endfunction

  // round half up by k bits, floor shift (arith)
  function automatic longint round_sh(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [17:0] clamp_pos(longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return -18'sd131072;
    return v[17:0];
  endfunction

  function automatic pose_t predict_pose(logic [15:0] q1, q2, q3);
    pose_t  p;
    logic [23:0] p1, p2, p3, p23;
    longint s1, c1, s2, c2, s3, c3, s23, c23, sh, bh, ua, fa, wo, a, b, r, zq, xq, yq;
    p1 = {q1, 8'h00};
    p2 = {q2, 8'h00};
    p3 = {q3, 8'h00};
    p23 = p2 + p3;
    s1 = sine14(p1);   c1 = cosine14(p1);
    s2 = sine14(p2);   c2 = cosine14(p2);
    s3 = sine14(p3);   c3 = cosine14(p3);
    s23 = sine14(p23); c23 = cosine14(p23);
    sh = link_reg[REG_SHOULDER]; bh = link_reg[REG_BASE_H];
    ua = link_reg[REG_UPPER];    fa = link_reg[REG_FOREARM];
    wo = link_reg[REG_WRIST];
    a = wo * c3 - fa * s3;
    b = fa * c3 + wo * s3 + (ua <<< 14);
    r = s2 * a + c2 * b;
    zq = c2 * a - s2 * b + (bh <<< 28);
    xq = c1 * r - ((sh * s1) <<< 28);
    yq = s1 * r + ((sh * c1) <<< 28);
    p.rot[0] = s1[15:0];
    p.rot[1] = 16'(round_sh(c23 * c1, 14));
    p.rot[2] = 16'(round_sh(s23 * c1, 14));
    p.rot[3] = 16'(-c1);
    p.rot[4] = 16'(round_sh(c23 * s1, 14));
    p.rot[5] = 16'(round_sh(s23 * s1, 14));
    p.rot[6] = 16'(-s23);
    p.rot[7] = c23[15:0];
    p.pos[0] = clamp_pos(round_sh(xq, 42));
    p.pos[1] = clamp_pos(round_sh(yq, 42));
    p.pos[2] = clamp_pos(round_sh(zq, 28));
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      pose_t want;
      if (pose_q.size() == 0) begin
        report_mismatch("unexpected pose", 0, 0);
      end else begin
        want = pose_q.pop_front();
        for (int i = 0; i < 8; i++)
          if ($signed(out_tdata[16*i +: 16]) != want.rot[i])
            report_mismatch($sformatf("rot field %0d", i),
                            $signed(out_tdata[16*i +: 16]), want.rot[i]);
        for (int i = 0; i < 3; i++)
          if ($signed(out_tdata[128 + 18*i +: 18]) != want.pos[i])
            report_mismatch($sformatf("pos field %0d", i),
                            $signed(out_tdata[128 + 18*i +: 18]), want.pos[i]);
      end
    end
  end

  // receiver back pressure, about 21 in a hundred, none in the quiet stretch
  always @(posedge clk)
    out_tready <= hold_off_idle ? 1'b1 : ($urandom_range(99) >= 21);

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------
  // cfg_valid drops after each write, which keeps back-to-back writes apart
  task automatic write_link(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_WRIST) link_reg[idx] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender gaps come before the item so valid stays high until the item is taken
  task automatic send_angles(logic [15:0] q1, q2, q3);
    if (!hold_off_idle)
      while ($urandom_range(99) < 21) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    in_tvalid <= 1'b1;
    in_tdata  <= {q3, q2, q1};
    do @(posedge clk); while (!in_tready);
    pose_q.push_back(predict_pose(q1, q2, q3));
  endtask

  task automatic drain_poses();
    in_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'($urandom_range(3)) << 14; // quadrant edges
      1: return (16'($urandom_range(3)) << 14) + 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  angle_row_t angle_table [] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 16'hC000},
    '{16'h4000, 16'h0000, 16'h0000, 1, 16'h4000, 16'h0000},
    '{16'h8000, 16'h0000, 16'h0000, 1, 16'h0000, 16'h4000},
    '{16'hC000, 16'h0000, 16'h0000, 1, 16'hC000, 16'h0000},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0},
    '{16'h0000, 16'h4000, 16'h0000, 0, 0, 0},
    '{16'h0000, 16'h8000, 16'h8000, 0, 0, 0},
    '{16'h0000, 16'hC000, 16'h4000, 0, 0, 0},
    '{16'h2000, 16'h2000, 16'h2000, 0, 0, 0},
    '{16'h5555, 16'hAAAA, 16'h5555, 0, 0, 0},
    '{16'hAAAA, 16'h5555, 16'hAAAA, 0, 0, 0},
    '{16'h0001, 16'h7FFF, 16'h8001, 0, 0, 0},
    '{16'h3FFF, 16'hBFFF, 16'h4001, 0, 0, 0},
    '{16'h1234, 16'hF000, 16'h0FFF, 0, 0, 0}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] link_set [4][5];
    pose_t       want;
    link_reg = '{16'd7143, 16'd5846, 16'd27853, 16'd31850, 16'd13959};
    link_set[0] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    link_set[1] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
    link_set[2] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF};
    link_set[3] = '{16'd7143, 16'd5846, 16'd27853, 16'd31850, 16'd13959};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at the reset link offsets
    foreach (angle_table[i]) begin
      send_angles(angle_table[i].q1, angle_table[i].q2, angle_table[i].q3);
      if (angle_table[i].fixed) begin
        want = pose_q[$];
        want.rot[0] = angle_table[i].r00;
        want.rot[3] = angle_table[i].r10;
        pose_q[$] = want;
      end
    end
    drain_poses();

    // out-of-range register index must be ignored
    write_link(3'd5, 16'hFFFF);
    write_link(3'd7, 16'h1234);

    // random phases over several link settings, extremes first
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 5; r++)
        write_link(r[2:0], ph < 4 ? link_set[ph][r] : 16'($urandom));
      hold_off_idle = (ph == 3);
      for (int n = 0; n < 160; n++)
        send_angles(rand_angle(), rand_angle(), rand_angle());
      hold_off_idle = 0;
      drain_poses();
    end

    if (mismatch_count == 0) begin
      $display("PASS arm_forward_kinematics_3dof");
    end else begin
      $display("FAIL arm_forward_kinematics_3dof");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("FAIL arm_forward_kinematics_3dof");
    $finish;
  end

endmodule

FILE: filelist.f
design/afk_pkg.sv
design/afk_front.sv
design/afk_back.sv
design/afk_cfg.sv
design/arm_forward_kinematics_3dof.sv
verif/tb_top.sv
